/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Wrappers for clocked concurrent assertions; empty when synthesizing.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
// Whenever the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`endif

`endif

/* rtl/qpht_pkg.sv */
// ---------------------------------------------------------------------------
// qpht_pkg
// Shared sizes and codes of the quadratic probing hash table.
// ---------------------------------------------------------------------------
`default_nettype none

package qpht_pkg;

   // Number of slots; a power of two so that the modulo is a mask.
   localparam int unsigned TABLE_SIZE = 1024;
   localparam int unsigned SLOT_W     = $clog2(TABLE_SIZE);
   localparam int unsigned COUNT_W    = $clog2(TABLE_SIZE + 1);
   localparam int unsigned KEY_W      = 64;
   localparam int unsigned VALUE_W    = 32;

   // Operation codes of a request.
   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_LOOKUP = 1'b1;

   // Result codes.
   typedef enum logic [1:0] {
      ST_STORED = 2'd0,
      ST_FULL   = 2'd1,
      ST_HIT    = 2'd2,
      ST_MISS   = 2'd3
   } status_type;

endpackage

`default_nettype wire

/* rtl/qpht_req_if.sv */
// ---------------------------------------------------------------------------
// qpht_req_if
// Request channel: operation, key hash and value with valid/ready.
// ---------------------------------------------------------------------------
`default_nettype none

interface qpht_req_if;
   logic                           valid;
   logic                           ready;
   logic                           func;
   logic [qpht_pkg::KEY_W-1:0]     key_hash;
   logic [qpht_pkg::VALUE_W-1:0]   value;

   modport source (output valid, output func, output key_hash, output value, input ready);
   modport sink   (input valid, input func, input key_hash, input value, output ready);
endinterface

`default_nettype wire

/* rtl/qpht_rsp_if.sv */
// ---------------------------------------------------------------------------
// qpht_rsp_if
// Response channel: status, read value, slot and entry count with valid/ready.
// ---------------------------------------------------------------------------
`default_nettype none

interface qpht_rsp_if;
   logic                           valid;
   logic                           ready;
   qpht_pkg::status_type           status;
   logic [qpht_pkg::VALUE_W-1:0]   read_value;
   logic [qpht_pkg::SLOT_W-1:0]    slot;
   logic [qpht_pkg::COUNT_W-1:0]   entry_total;

   modport source (output valid, output status, output read_value, output slot,
                   output entry_total, input ready);
   modport sink   (input valid, input status, input read_value, input slot,
                   input entry_total, output ready);
endinterface

`default_nettype wire

/* rtl/quadratic_probe_hash_table.sv */
// ---------------------------------------------------------------------------
// quadratic_probe_hash_table
// Open-addressed hash table with quadratic probing over one entry memory.
// ---------------------------------------------------------------------------
//
//   Channel   Direction   Contents
//   req_if    in          func (insert/lookup), key_hash, value
//   rsp_if    out         status, read_value, slot, entry_total
//
// A request is accepted in the idle state, probes one slot at a time
// through the single memory read port, and then hands its result to the
// output register once that register is free.
// After reset a clearing pass marks every slot empty and holds
// off requests. A new request is taken while a result still waits on a
// stalled response channel; a second result then holds the block.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module quadratic_probe_hash_table (
   input  wire logic  clock,
   input  wire logic  reset,
   qpht_req_if.sink   req_if,
   qpht_rsp_if.source rsp_if
);

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_PROBE,
      S_FINISH
   } state_type;

   // One memory word per slot: the valid flag travels with the hash and data,
   // so a single read per probe gives everything the compare needs.
   typedef struct packed {
      logic                           valid;
      logic [qpht_pkg::KEY_W-1:0]     hash;
      logic [qpht_pkg::VALUE_W-1:0]   data;
   } entry_type;

   entry_type mem [qpht_pkg::TABLE_SIZE];

   entry_type                       rd_entry_ff;
   logic                            mem_we;
   logic [qpht_pkg::SLOT_W-1:0]     mem_waddr;
   entry_type                       mem_wdata;
   logic [qpht_pkg::SLOT_W-1:0]     mem_raddr;

   state_type                       state_ff,      state_in;
   logic [qpht_pkg::SLOT_W-1:0]     clr_ff,        clr_in;
   logic [qpht_pkg::COUNT_W-1:0]    count_ff,      count_in;
   logic                            func_ff,       func_in;
   logic [qpht_pkg::KEY_W-1:0]      hash_ff,       hash_in;
   logic [qpht_pkg::VALUE_W-1:0]    value_ff,      value_in;
   logic [qpht_pkg::SLOT_W-1:0]     slot_ff,       slot_in;
   logic [qpht_pkg::SLOT_W-1:0]     step_ff,       step_in;
   qpht_pkg::status_type            res_status_ff, res_status_in;
   logic [qpht_pkg::VALUE_W-1:0]    res_value_ff,  res_value_in;
   logic [qpht_pkg::SLOT_W-1:0]     res_slot_ff,   res_slot_in;
   logic                            rsp_valid_ff,  rsp_valid_in;
   qpht_pkg::status_type            rsp_status_ff, rsp_status_in;
   logic [qpht_pkg::VALUE_W-1:0]    rsp_value_ff,  rsp_value_in;
   logic [qpht_pkg::SLOT_W-1:0]     rsp_slot_ff,   rsp_slot_in;
   logic [qpht_pkg::COUNT_W-1:0]    rsp_total_ff,  rsp_total_in;

   logic                            accept;
   logic                            probe_hit;
   logic                            last_probe;
   logic [qpht_pkg::SLOT_W-1:0]     home_slot;
   logic [qpht_pkg::SLOT_W-1:0]     slot_next;

   assign req_if.ready       = (state_ff == S_IDLE);
   assign accept             = req_if.valid && req_if.ready;

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.status      = rsp_status_ff;
   assign rsp_if.read_value  = rsp_value_ff;
   assign rsp_if.slot        = rsp_slot_ff;
   assign rsp_if.entry_total = rsp_total_ff;

   // The home slot is the hash modulo the table size, i.e. its low bits.
   assign home_slot = req_if.key_hash[qpht_pkg::SLOT_W-1:0];

   // Successive squares differ by 2i+1, so the next probe is the current slot
   // plus 2i+1, wrapping at the table size.
   assign slot_next = slot_ff + {step_ff[qpht_pkg::SLOT_W-2:0], 1'b1};

   // An insert stops at the first empty slot; a lookup stops at the first
   // valid slot with an equal hash and walks past empty ones.
   assign probe_hit = (func_ff == qpht_pkg::FUNC_INSERT) ? !rd_entry_ff.valid
                    : (rd_entry_ff.valid && (rd_entry_ff.hash == hash_ff));
   assign last_probe = (step_ff == qpht_pkg::SLOT_W'(qpht_pkg::TABLE_SIZE - 1));

   // The read address runs one probe ahead of the compare: while the data of
   // probe i is checked, probe i+1 is already being read. Nothing is written
   // until the probe sequence ends, so the look-ahead never reads stale data.
   assign mem_raddr = (state_ff == S_IDLE) ? home_slot : slot_next;

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      count_in      = count_ff;
      func_in       = func_ff;
      hash_in       = hash_ff;
      value_in      = value_ff;
      slot_in       = slot_ff;
      step_in       = step_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      res_slot_in   = res_slot_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_total_in  = rsp_total_ff;
      mem_we        = 1'b0;
      mem_waddr     = slot_ff;
      mem_wdata     = '{valid: 1'b1, hash: hash_ff, data: value_ff};

      case (state_ff)
         S_CLEAR: begin
            // Sweep the memory once, marking every slot empty.
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               func_in  = req_if.func;
               hash_in  = req_if.key_hash;
               value_in = req_if.value;
               slot_in  = home_slot;
               step_in  = '0;
               state_in = S_PROBE;
            end
         end
         S_PROBE: begin
            if (probe_hit) begin
               res_slot_in = slot_ff;
               if (func_ff == qpht_pkg::FUNC_INSERT) begin
                  mem_we        = 1'b1;
                  count_in      = count_ff + 1'b1;
                  res_status_in = qpht_pkg::ST_STORED;
                  res_value_in  = '0;
               end else begin
                  res_status_in = qpht_pkg::ST_HIT;
                  res_value_in  = rd_entry_ff.data;
               end
               state_in = S_FINISH;
            end else if (last_probe) begin
               // Every slot on the probe sequence was visited without success.
               res_status_in = (func_ff == qpht_pkg::FUNC_INSERT) ? qpht_pkg::ST_FULL
                                                                  : qpht_pkg::ST_MISS;
               res_value_in  = '0;
               res_slot_in   = '0;
               state_in      = S_FINISH;
            end else begin
               slot_in = slot_next;
               step_in = step_ff + 1'b1;
            end
         end
         S_FINISH: begin
            // Move the result into the output register once it is free.
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_value_in  = res_value_ff;
               rsp_slot_in   = res_slot_ff;
               rsp_total_in  = count_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_entry_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff       <= func_in;
      hash_ff       <= hash_in;
      value_ff      <= value_in;
      slot_ff       <= slot_in;
      step_ff       <= step_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      res_slot_ff   <= res_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_total_ff  <= rsp_total_in;
   end

   // The occupancy can never pass the number of slots.
   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= qpht_pkg::COUNT_W'(qpht_pkg::TABLE_SIZE))
   // The occupancy only ever moves up by one, on a store.
   `ASSERT_IMPLIES(a_count_step, clock, reset, count_in != count_ff, count_in == count_ff + 1'b1)
   // A fresh response only appears out of the finishing state.
   `ASSERT_IMPLIES(a_rsp_source, clock, reset, !rsp_valid_ff && rsp_valid_in, state_ff == S_FINISH)

endmodule

`default_nettype wire
